// ===== src/sikt_pkg.sv =====
package sikt_pkg;

  localparam int MAX_ENTRIES   = 254;
  localparam int MAX_KEY_BYTES = 255;
  localparam int STORE_DEPTH   = MAX_ENTRIES * MAX_KEY_BYTES;

  localparam int BYTE_W  = 8;
  localparam int SLOT_W  = $clog2(MAX_ENTRIES + 1);
  localparam int LEN_W   = $clog2(MAX_KEY_BYTES + 1);
  localparam int BUF_AW  = $clog2(MAX_KEY_BYTES);
  localparam int LEN_AW  = $clog2(MAX_ENTRIES);
  localparam int STORE_AW = $clog2(STORE_DEPTH);

  localparam logic [SLOT_W-1:0]   MAX_ENTRIES_V   = SLOT_W'(MAX_ENTRIES);
  localparam logic [LEN_W-1:0]    MAX_KEY_BYTES_V = LEN_W'(MAX_KEY_BYTES);
  localparam logic [STORE_AW-1:0] ROW_STRIDE      = STORE_AW'(MAX_KEY_BYTES);

  localparam logic [7:0] IDX_EMPTY  = 8'd0;
  localparam logic [7:0] IDX_REJECT = 8'd255;

  typedef struct packed {
    logic              we;
    logic [BUF_AW-1:0] waddr;
    logic [BYTE_W-1:0] wdata;
    logic [BUF_AW-1:0] raddr;
  } buf_req_t;

  typedef struct packed {
    logic                we;
    logic [STORE_AW-1:0] waddr;
    logic [BYTE_W-1:0]   wdata;
    logic [STORE_AW-1:0] raddr;
  } store_req_t;

  typedef struct packed {
    logic              we;
    logic [LEN_AW-1:0] waddr;
    logic [LEN_W-1:0]  wdata;
    logic [LEN_AW-1:0] raddr;
  } len_req_t;

endpackage

// ===== src/sikt_ram.sv =====
module sikt_ram #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 8,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== src/sikt_ctrl.sv =====
module sikt_ctrl (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [7:0]                    in_key_byte,
  input  logic                          in_key_last,
  input  logic                          in_key_empty,
  output logic                          busy,
  output logic                          out_valid,
  output logic [7:0]                    out_key_index,
  output sikt_pkg::buf_req_t            buf_req,
  input  logic [sikt_pkg::BYTE_W-1:0]   buf_rdata,
  output sikt_pkg::store_req_t          store_req,
  input  logic [sikt_pkg::BYTE_W-1:0]   store_rdata,
  output sikt_pkg::len_req_t            len_req,
  input  logic [sikt_pkg::LEN_W-1:0]    len_rdata
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_LRD  = 3'd1;
  localparam logic [2:0] S_LCHK = 3'd2;
  localparam logic [2:0] S_CMP  = 3'd3;
  localparam logic [2:0] S_INS  = 3'd4;

  logic [2:0]                      state_r, state_nxt;
  logic [sikt_pkg::SLOT_W-1:0]     cnt_r, cnt_nxt;
  logic [sikt_pkg::LEN_W-1:0]      klen_r, klen_nxt;
  logic                            tl_r, tl_nxt;
  logic [sikt_pkg::SLOT_W-1:0]     slot_r, slot_nxt;
  logic [sikt_pkg::STORE_AW-1:0]   base_r, base_nxt;
  logic [sikt_pkg::LEN_W-1:0]      idx_r, idx_nxt;
  logic                            pend_r, pend_nxt;
  logic                            plast_r, plast_nxt;
  logic [sikt_pkg::STORE_AW-1:0]   paddr_r, paddr_nxt;
  logic                            ov_r, ov_nxt;
  logic [7:0]                      oidx_r, oidx_nxt;

  logic                            accept;
  logic                            add_byte;
  logic                            tl_now;
  logic [sikt_pkg::LEN_W-1:0]      flen;
  logic                            issue;
  logic                            adv;

  assign accept   = start && (state_r == S_IDLE);
  assign add_byte = !in_key_empty && (klen_r != sikt_pkg::MAX_KEY_BYTES_V);
  assign tl_now   = tl_r || (!in_key_empty && (klen_r == sikt_pkg::MAX_KEY_BYTES_V));
  assign flen     = klen_r + sikt_pkg::LEN_W'(add_byte);
  assign issue    = (idx_r != klen_r);

  always_comb begin
    buf_req.we    = accept && add_byte;
    buf_req.waddr = sikt_pkg::BUF_AW'(klen_r);
    buf_req.wdata = in_key_byte;
    buf_req.raddr = sikt_pkg::BUF_AW'(idx_r);

    store_req.we    = (state_r == S_INS) && pend_r;
    store_req.waddr = paddr_r;
    store_req.wdata = buf_rdata;
    store_req.raddr = base_r + sikt_pkg::STORE_AW'(idx_r);

    len_req.we    = (state_r == S_INS) && pend_r && plast_r;
    len_req.waddr = sikt_pkg::LEN_AW'(cnt_r);
    len_req.wdata = klen_r;
    len_req.raddr = sikt_pkg::LEN_AW'(slot_r);
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    klen_nxt  = klen_r;
    tl_nxt    = tl_r;
    slot_nxt  = slot_r;
    base_nxt  = base_r;
    idx_nxt   = idx_r;
    pend_nxt  = pend_r;
    plast_nxt = plast_r;
    paddr_nxt = paddr_r;
    ov_nxt    = 1'b0;
    oidx_nxt  = oidx_r;
    adv       = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (!in_key_last) begin
            klen_nxt = flen;
            tl_nxt   = tl_now;
          end else begin
            tl_nxt   = 1'b0;
            klen_nxt = flen;
            slot_nxt = '0;
            base_nxt = '0;
            idx_nxt  = '0;
            pend_nxt = 1'b0;
            if (tl_now) begin
              ov_nxt   = 1'b1;
              oidx_nxt = sikt_pkg::IDX_REJECT;
              klen_nxt = '0;
            end else if (flen == '0) begin
              ov_nxt   = 1'b1;
              oidx_nxt = sikt_pkg::IDX_EMPTY;
            end else if (cnt_r == '0) begin
              state_nxt = S_INS;
            end else begin
              state_nxt = S_LRD;
            end
          end
        end
      end
      S_LRD: begin
        state_nxt = S_LCHK;
      end
      S_LCHK: begin
        if (len_rdata == klen_r) begin
          state_nxt = S_CMP;
          idx_nxt   = '0;
          pend_nxt  = 1'b0;
        end else begin
          adv = 1'b1;
        end
      end
      S_CMP: begin
        pend_nxt  = issue;
        plast_nxt = issue && (idx_r == klen_r - 1'b1);
        idx_nxt   = idx_r + sikt_pkg::LEN_W'(issue);
        if (pend_r && (buf_rdata != store_rdata)) begin
          adv = 1'b1;
        end else if (pend_r && plast_r) begin
          ov_nxt    = 1'b1;
          oidx_nxt  = 8'(slot_r + 1'b1);
          state_nxt = S_IDLE;
          klen_nxt  = '0;
        end
      end
      S_INS: begin
        pend_nxt  = issue;
        plast_nxt = issue && (idx_r == klen_r - 1'b1);
        idx_nxt   = idx_r + sikt_pkg::LEN_W'(issue);
        paddr_nxt = base_r + sikt_pkg::STORE_AW'(idx_r);
        if (pend_r && plast_r) begin
          ov_nxt    = 1'b1;
          oidx_nxt  = 8'(cnt_r + 1'b1);
          cnt_nxt   = cnt_r + 1'b1;
          state_nxt = S_IDLE;
          klen_nxt  = '0;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (adv) begin
      slot_nxt = slot_r + 1'b1;
      base_nxt = base_r + sikt_pkg::ROW_STRIDE;
      idx_nxt  = '0;
      pend_nxt = 1'b0;
      if (slot_r + 1'b1 == cnt_r) begin
        if (cnt_r != sikt_pkg::MAX_ENTRIES_V) begin
          state_nxt = S_INS;
        end else begin
          ov_nxt    = 1'b1;
          oidx_nxt  = sikt_pkg::IDX_REJECT;
          state_nxt = S_IDLE;
          klen_nxt  = '0;
        end
      end else begin
        state_nxt = S_LRD;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      klen_r  <= '0;
      tl_r    <= 1'b0;
      pend_r  <= 1'b0;
      plast_r <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      klen_r  <= klen_nxt;
      tl_r    <= tl_nxt;
      pend_r  <= pend_nxt;
      plast_r <= plast_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    slot_r  <= slot_nxt;
    base_r  <= base_nxt;
    idx_r   <= idx_nxt;
    paddr_r <= paddr_nxt;
    oidx_r  <= oidx_nxt;
  end

  assign busy          = (state_r != S_IDLE);
  assign out_valid     = ov_r;
  assign out_key_index = oidx_r;

endmodule

// ===== src/string_key_interning_table_unit.sv =====
// Key bytes are taken one beat per cycle while busy is low; a beat with
// in_key_last high ends the key and yields exactly one result, shown for one
// cycle with out_valid, which the receiver must take as it comes. An empty or
// too-long key answers in the cycle after its last beat. Otherwise the unit walks
// the stored keys in insertion order through the length memory and the key
// store, each with one read port: a stored key of another length is passed over
// on its length alone, one of equal length is compared byte by byte, and a new
// key is copied in byte by byte, or rejected when all 254 entries are taken.
// busy stays high for that whole walk, and the answer is shown as busy falls.
module string_key_interning_table_unit (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  logic [7:0] in_key_byte,
  input  logic       in_key_last,
  input  logic       in_key_empty,
  output logic       busy,
  output logic       out_valid,
  output logic [7:0] out_key_index
);

  sikt_pkg::buf_req_t                buf_req;
  sikt_pkg::store_req_t              store_req;
  sikt_pkg::len_req_t                len_req;
  logic [sikt_pkg::BYTE_W-1:0]       buf_rdata;
  logic [sikt_pkg::BYTE_W-1:0]       store_rdata;
  logic [sikt_pkg::LEN_W-1:0]        len_rdata;

  sikt_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .in_key_byte  (in_key_byte),
    .in_key_last  (in_key_last),
    .in_key_empty (in_key_empty),
    .busy         (busy),
    .out_valid    (out_valid),
    .out_key_index(out_key_index),
    .buf_req      (buf_req),
    .buf_rdata    (buf_rdata),
    .store_req    (store_req),
    .store_rdata  (store_rdata),
    .len_req      (len_req),
    .len_rdata    (len_rdata)
  );

  sikt_ram #(
    .DEPTH(sikt_pkg::MAX_KEY_BYTES),
    .WIDTH(sikt_pkg::BYTE_W),
    .AW   (sikt_pkg::BUF_AW)
  ) u_buf_ram (
    .clk  (clk),
    .we   (buf_req.we),
    .waddr(buf_req.waddr),
    .wdata(buf_req.wdata),
    .raddr(buf_req.raddr),
    .rdata(buf_rdata)
  );

  sikt_ram #(
    .DEPTH(sikt_pkg::STORE_DEPTH),
    .WIDTH(sikt_pkg::BYTE_W),
    .AW   (sikt_pkg::STORE_AW)
  ) u_store_ram (
    .clk  (clk),
    .we   (store_req.we),
    .waddr(store_req.waddr),
    .wdata(store_req.wdata),
    .raddr(store_req.raddr),
    .rdata(store_rdata)
  );

  sikt_ram #(
    .DEPTH(sikt_pkg::MAX_ENTRIES),
    .WIDTH(sikt_pkg::LEN_W),
    .AW   (sikt_pkg::LEN_AW)
  ) u_len_ram (
    .clk  (clk),
    .we   (len_req.we),
    .waddr(len_req.waddr),
    .wdata(len_req.wdata),
    .raddr(len_req.raddr),
    .rdata(len_rdata)
  );

  a_mid_key_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && !in_key_last) |=> !out_valid)
    else $error("result after a beat that did not end a key");

  a_result_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result shown while the walk is still running");

  a_walk_end_result: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> out_valid)
    else $error("walk ended without a result");

  a_no_store_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (!busy) |-> (!store_req.we && !len_req.we))
    else $error("key store written outside an insert");

endmodule
